// ----- rtl/core/cdsc_pkg.sv -----
// cdsc_pkg: types, constants and calendar helper functions for the date-time step counter
// no dependencies; used by cdsc_step, cdsc_daynum and calendar_datetime_step_counter

package cdsc_pkg;

    // item kinds carried on the input tuser
    typedef enum logic [3:0] {
        MODE_LOAD      = 4'd0,
        MODE_ADD_SEC   = 4'd1,
        MODE_ADD_MIN   = 4'd2,
        MODE_ADD_HOUR  = 4'd3,
        MODE_ADD_DAY   = 4'd4,
        MODE_ADD_MONTH = 4'd5,
        MODE_ADD_YEAR  = 4'd6,
        MODE_SUB_SEC   = 4'd7,
        MODE_SUB_MIN   = 4'd8,
        MODE_SUB_HOUR  = 4'd9,
        MODE_SUB_DAY   = 4'd10,
        MODE_SUB_MONTH = 4'd11,
        MODE_SUB_YEAR  = 4'd12
    } mode_t;

    // second sits in the low bits, year in the high bits
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } datetime_t;

    localparam logic [13:0] MAX_YEAR    = 14'd9999;
    localparam logic [13:0] RESET_YEAR  = 14'd2000;
    localparam logic [5:0]  LAST_SEC    = 6'd59;
    localparam logic [5:0]  LAST_MIN    = 6'd59;
    localparam logic [4:0]  LAST_HOUR   = 5'd23;
    localparam logic [3:0]  LAST_MONTH  = 4'd12;
    localparam logic [14:0] YEAR_SHIFT  = 15'd4800;
    localparam logic [23:0] DAYS_YEAR   = 24'd365;
    localparam logic [23:0] DAY_BIAS    = 24'd32083;
    // inverse of 25 modulo 2**14, and the largest 14-bit quotient of an exact multiple
    localparam logic [27:0] INV25       = 28'd7209;
    localparam logic [13:0] DIV25_LIMIT = 14'd655;

    // gregorian leap year; divisibility by 25 through the modular inverse
    function automatic logic is_leap(input logic [13:0] y);
        logic [27:0] prod;
        logic        div25;
        logic        div4;
        logic        div16;
        prod  = 28'(y) * INV25;
        div25 = (prod[13:0] <= DIV25_LIMIT);
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        return (div4 && !div25) || (div16 && div25);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // (153*m + 2)/5 with m counted from march
    function automatic logic [8:0] month_offset(input logic [3:0] month);
        logic [8:0] ofs;
        case (month)
            4'd3:    ofs = 9'd0;
            4'd4:    ofs = 9'd31;
            4'd5:    ofs = 9'd61;
            4'd6:    ofs = 9'd92;
            4'd7:    ofs = 9'd122;
            4'd8:    ofs = 9'd153;
            4'd9:    ofs = 9'd184;
            4'd10:   ofs = 9'd214;
            4'd11:   ofs = 9'd245;
            4'd12:   ofs = 9'd275;
            4'd1:    ofs = 9'd306;
            4'd2:    ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

// ----- rtl/core/calendar_datetime_step_counter.sv -----
// calendar_datetime_step_counter: top level of the calendar date-time step counter
// depends on cdsc_pkg, cdsc_step and cdsc_daynum
//
// channel   dir  tdata (low bit up)                                  tuser
// s_axis    in   load_second, load_minute, load_hour, load_day,      mode
//                load_month, load_year, 40 bits
// m_axis    out  cur_second, cur_minute, cur_hour, cur_day,          load_error
//                cur_month, cur_year, day_number, pad bit, 64 bits
//
// one transaction in, one transaction out; one item per clock while the result is taken
// an item passes the input register, then the step and day-number logic into the
// result register, which also holds the updated date-time
// rst_n clears the date-time to 2000-01-01 00:00:00 and empties both registers
// a stalled result holds; the input register still takes one more item, then
// s_axis_tready drops until the result is taken

module calendar_datetime_step_counter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // load_second, load_minute, load_hour, load_day,
                                        // load_month, load_year
    input  logic [3:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // cur_second, cur_minute, cur_hour, cur_day,
                                        // cur_month, cur_year, day_number, zero pad
    output logic [0:0]  m_axis_tuser    // load_error
);

    // input stage
    logic                in_valid_reg,  in_valid_next;
    cdsc_pkg::mode_t     in_mode_reg,   in_mode_next;
    cdsc_pkg::datetime_t in_load_reg,   in_load_next;

    // calendar state
    cdsc_pkg::datetime_t cur_reg,       cur_next;

    // result stage
    logic                out_valid_reg, out_valid_next;
    logic [63:0]         out_data_reg,  out_data_next;
    logic                out_error_reg, out_error_next;

    logic                s_fire;
    logic                advance;
    cdsc_pkg::datetime_t step_dt;
    logic                step_error;
    logic [22:0]         step_daynum;

    // the held item moves on whenever the result slot is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    cdsc_step u_step (
        .cur        (cur_reg),
        .mode       (in_mode_reg),
        .load       (in_load_reg),
        .nxt        (step_dt),
        .load_error (step_error)
    );

    // the day number is taken from the date after the step
    cdsc_daynum u_daynum (
        .dt         (step_dt),
        .day_number (step_daynum)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_mode_next   = in_mode_reg;
        in_load_next   = in_load_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_error_next = out_error_reg;

        if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (s_fire)
        begin
            in_valid_next = 1'b1;
            in_mode_next  = cdsc_pkg::mode_t'(s_axis_tuser);
            in_load_next  = cdsc_pkg::datetime_t'(s_axis_tdata);
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            // the state and the result change together, in item order
            cur_next       = step_dt;
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, step_daynum, step_dt};
            out_error_next = step_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_reg.second <= 6'd0;
            cur_reg.minute <= 6'd0;
            cur_reg.hour   <= 5'd0;
            cur_reg.day    <= 5'd1;
            cur_reg.month  <= 4'd1;
            cur_reg.year   <= cdsc_pkg::RESET_YEAR;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_mode_reg   <= in_mode_next;
        in_load_reg   <= in_load_next;
        out_data_reg  <= out_data_next;
        out_error_reg <= out_error_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_error_reg;

`ifndef SYNTHESIS
    // an item leaving the input stage always shows up as a result
    a_advance_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("item advanced without a result");

    // a rejected load leaves the calendar untouched
    a_error_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_error) |=> (cur_reg == $past(cur_reg)))
        else $error("rejected load changed the date-time");

    // time of day and year stay within range
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg.second <= cdsc_pkg::LAST_SEC) && (cur_reg.minute <= cdsc_pkg::LAST_MIN) &&
        (cur_reg.hour <= cdsc_pkg::LAST_HOUR) && (cur_reg.year <= cdsc_pkg::MAX_YEAR))
        else $error("time or year out of range");

    // month stays within 1 to 12 and day never falls to zero
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg.month >= 4'd1) && (cur_reg.month <= cdsc_pkg::LAST_MONTH) &&
        (cur_reg.day != 5'd0))
        else $error("month or day out of range");
`endif

endmodule

// ----- rtl/core/cdsc_step.sv -----
// cdsc_step: next date-time for one item (load with checks, or one step up or down)
// depends on cdsc_pkg

module cdsc_step (
    input  cdsc_pkg::datetime_t cur,
    input  cdsc_pkg::mode_t     mode,
    input  cdsc_pkg::datetime_t load,
    output cdsc_pkg::datetime_t nxt,
    output logic                load_error
);

    logic       s_inc, m_inc, h_inc, d_inc, mo_inc, y_inc;
    logic       s_dec, m_dec, h_dec, d_dec, mo_dec, y_dec;
    logic [4:0] len_cur;
    logic [4:0] len_new;
    logic [4:0] len_load;
    logic       load_ok;
    logic [3:0] month_new;
    logic [13:0] year_new;
    cdsc_pkg::datetime_t stepped;

    assign len_cur  = cdsc_pkg::month_len(cur.month, cdsc_pkg::is_leap(cur.year));
    assign len_load = cdsc_pkg::month_len(load.month, cdsc_pkg::is_leap(load.year));

    // carry chain upward
    assign s_inc  = (mode == cdsc_pkg::MODE_ADD_SEC);
    assign m_inc  = (mode == cdsc_pkg::MODE_ADD_MIN)   || (s_inc && cur.second >= cdsc_pkg::LAST_SEC);
    assign h_inc  = (mode == cdsc_pkg::MODE_ADD_HOUR)  || (m_inc && cur.minute >= cdsc_pkg::LAST_MIN);
    assign d_inc  = (mode == cdsc_pkg::MODE_ADD_DAY)   || (h_inc && cur.hour >= cdsc_pkg::LAST_HOUR);
    assign mo_inc = (mode == cdsc_pkg::MODE_ADD_MONTH) || (d_inc && cur.day >= len_cur);
    assign y_inc  = (mode == cdsc_pkg::MODE_ADD_YEAR)  || (mo_inc && cur.month >= cdsc_pkg::LAST_MONTH);

    // borrow chain downward; a day more than one past the month end borrows too
    assign s_dec  = (mode == cdsc_pkg::MODE_SUB_SEC);
    assign m_dec  = (mode == cdsc_pkg::MODE_SUB_MIN)   || (s_dec && cur.second == 6'd0);
    assign h_dec  = (mode == cdsc_pkg::MODE_SUB_HOUR)  || (m_dec && cur.minute == 6'd0);
    assign d_dec  = (mode == cdsc_pkg::MODE_SUB_DAY)   || (h_dec && cur.hour == 5'd0);
    assign mo_dec = (mode == cdsc_pkg::MODE_SUB_MONTH) ||
                    (d_dec && (cur.day <= 5'd1 || 6'(cur.day) > 6'(len_cur) + 6'd1));
    assign y_dec  = (mode == cdsc_pkg::MODE_SUB_YEAR)  || (mo_dec && cur.month <= 4'd1);

    always_comb
    begin
        if (y_inc)
        begin
            year_new = (cur.year >= cdsc_pkg::MAX_YEAR) ? 14'd0 : cur.year + 14'd1;
        end
        else if (y_dec)
        begin
            year_new = (cur.year == 14'd0 || cur.year > cdsc_pkg::MAX_YEAR) ?
                       cdsc_pkg::MAX_YEAR : cur.year - 14'd1;
        end
        else
        begin
            year_new = cur.year;
        end

        if (mo_inc)
        begin
            month_new = (cur.month >= cdsc_pkg::LAST_MONTH) ? 4'd1 : cur.month + 4'd1;
        end
        else if (mo_dec)
        begin
            month_new = (cur.month <= 4'd1) ? cdsc_pkg::LAST_MONTH : cur.month - 4'd1;
        end
        else
        begin
            month_new = cur.month;
        end
    end

    assign len_new = cdsc_pkg::month_len(month_new, cdsc_pkg::is_leap(year_new));

    always_comb
    begin
        stepped       = cur;
        stepped.year  = year_new;
        stepped.month = month_new;

        if (s_inc)
        begin
            stepped.second = (cur.second >= cdsc_pkg::LAST_SEC) ? 6'd0 : cur.second + 6'd1;
        end
        else if (s_dec)
        begin
            stepped.second = (cur.second == 6'd0) ? cdsc_pkg::LAST_SEC : cur.second - 6'd1;
        end

        if (m_inc)
        begin
            stepped.minute = (cur.minute >= cdsc_pkg::LAST_MIN) ? 6'd0 : cur.minute + 6'd1;
        end
        else if (m_dec)
        begin
            stepped.minute = (cur.minute == 6'd0) ? cdsc_pkg::LAST_MIN : cur.minute - 6'd1;
        end

        if (h_inc)
        begin
            stepped.hour = (cur.hour >= cdsc_pkg::LAST_HOUR) ? 5'd0 : cur.hour + 5'd1;
        end
        else if (h_dec)
        begin
            stepped.hour = (cur.hour == 5'd0) ? cdsc_pkg::LAST_HOUR : cur.hour - 5'd1;
        end

        if (d_inc)
        begin
            stepped.day = mo_inc ? 5'd1 : cur.day + 5'd1;
        end
        else if (d_dec)
        begin
            // borrow lands on the last day of the previous month
            stepped.day = mo_dec ? len_new : cur.day - 5'd1;
        end
    end

    assign load_ok = (load.second <= cdsc_pkg::LAST_SEC) &&
                     (load.minute <= cdsc_pkg::LAST_MIN) &&
                     (load.hour <= cdsc_pkg::LAST_HOUR) &&
                     (load.month >= 4'd1) && (load.month <= cdsc_pkg::LAST_MONTH) &&
                     (load.year <= cdsc_pkg::MAX_YEAR) &&
                     (load.day >= 5'd1) && (load.day <= len_load);

    always_comb
    begin
        if (mode == cdsc_pkg::MODE_LOAD)
        begin
            nxt        = load_ok ? load : cur;
            load_error = !load_ok;
        end
        else
        begin
            nxt        = stepped;
            load_error = 1'b0;
        end
    end

endmodule

// ----- rtl/core/cdsc_daynum.sv -----
// cdsc_daynum: day number of a date, day + (153*m + 2)/5 + 365*y + y/4 - 32083
// depends on cdsc_pkg

module cdsc_daynum (
    input  cdsc_pkg::datetime_t dt,
    output logic [22:0]         day_number
);

    logic        early;
    logic [14:0] y_shift;
    logic [23:0] sum;

    // january and february count as months of the previous year
    assign early   = (dt.month <= 4'd2);
    assign y_shift = 15'(dt.year) + cdsc_pkg::YEAR_SHIFT - 15'(early);
    assign sum     = 24'(dt.day) + 24'(cdsc_pkg::month_offset(dt.month)) +
                     24'(y_shift) * cdsc_pkg::DAYS_YEAR + 24'(y_shift[14:2]) -
                     cdsc_pkg::DAY_BIAS;
    assign day_number = sum[22:0];

endmodule

// ----- tb/testbench.sv -----
// testbench for calendar_datetime_step_counter: directed table, then random load and step items
// needs cdsc_pkg and the rtl of the block; carries its own calendar model to predict every result
`timescale 1ns / 1ps

module testbench;
    import cdsc_pkg::*;

    // one input transaction: mode on tuser, load fields on tdata (second lowest, year highest)
    typedef struct packed {
        logic [3:0] mode;
        datetime_t  load;
    } step_item_t;

    // one output transaction as it sits on {tuser, tdata[62:0]}
    typedef struct packed {
        logic        load_error;
        logic [22:0] day_number;
        datetime_t   dt;
    } calendar_result_t;

    // directed row: item plus, where it is obvious, the result typed in by hand
    typedef struct {
        step_item_t       item;
        bit               typed;
        calendar_result_t want;
    } stim_row_t;

    // idling phases of the run
    typedef enum int {
        PH_STEADY         = 0,
        PH_SENDER_IDLE    = 1,
        PH_RECEIVER_STALL = 2,
        PH_BOTH_IDLE      = 3
    } idle_phase_t;

    // modes past the last step code do nothing
    localparam logic [3:0] MODE_SPARE_LO = 4'd13;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    localparam int ITEMS_PER_PHASE = 450;
    localparam int MAX_SENDER_GAP  = 40;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 1000;

    // idle percentage per phase, indexed by idle_phase_t
    localparam int SEND_IDLE_PCT [4] = '{0, 73, 0, 16};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 73, 16};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // load_second, load_minute, load_hour, load_day,
                                      // load_month, load_year
    logic [3:0]  s_axis_tuser = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // cur_second, cur_minute, cur_hour, cur_day,
                                      // cur_month, cur_year, day_number, zero pad
    logic [0:0]  m_axis_tuser;        // load_error

    // calendar state as the block should hold it
    datetime_t        cal_now;
    calendar_result_t expected_results[$];
    stim_row_t        stim_rows[$];
    idle_phase_t      phase = PH_STEADY;
    int               error_count = 0;
    int               stall_cycles = 0;

    calendar_datetime_step_counter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // calendar model
    // ---------------------------------------------------------------

    // gregorian rule: every 4th year, not every 100th, but every 400th
    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(int m, int y);
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // year wraps both ways between 0 and the top year
    function automatic datetime_t step_year(datetime_t t, bit up);
        if (up)
            t.year = (t.year >= MAX_YEAR) ? 14'd0 : t.year + 14'd1;
        else
            t.year = (t.year == 14'd0 || t.year > MAX_YEAR) ? MAX_YEAR : t.year - 14'd1;
        return t;
    endfunction

    // month steps leave the day alone, even past the end of the new month
    function automatic datetime_t step_month(datetime_t t, bit up);
        if (up)
        begin
            if (t.month >= LAST_MONTH)
            begin
                t.month = 4'd1;
                t = step_year(t, 1'b1);
            end
            else
                t.month = t.month + 4'd1;
        end
        else
        begin
            if (t.month <= 4'd1)
            begin
                t.month = LAST_MONTH;
                t = step_year(t, 1'b0);
            end
            else
                t.month = t.month - 4'd1;
        end
        return t;
    endfunction

    // a day past the month end moves forward to the 1st of the next month; going down, a day more
    // than one past the end moves back to the last day of the previous one
    function automatic datetime_t step_day(datetime_t t, bit up);
        int len;
        len = days_in_month(int'(t.month), int'(t.year));
        if (up)
        begin
            if (int'(t.day) + 1 > len)
            begin
                t.day = 5'd1;
                t = step_month(t, 1'b1);
            end
            else
                t.day = t.day + 5'd1;
        end
        else
        begin
            if (t.day <= 5'd1 || int'(t.day) - 1 > len)
            begin
                t = step_month(t, 1'b0);
                t.day = 5'(days_in_month(int'(t.month), int'(t.year)));
            end
            else
                t.day = t.day - 5'd1;
        end
        return t;
    endfunction

    function automatic datetime_t step_hour(datetime_t t, bit up);
        if (up)
        begin
            if (t.hour >= LAST_HOUR)
            begin
                t.hour = 5'd0;
                t = step_day(t, 1'b1);
            end
            else
                t.hour = t.hour + 5'd1;
        end
        else
        begin
            if (t.hour == 5'd0)
            begin
                t.hour = LAST_HOUR;
                t = step_day(t, 1'b0);
            end
            else
                t.hour = t.hour - 5'd1;
        end
        return t;
    endfunction

    function automatic datetime_t step_minute(datetime_t t, bit up);
        if (up)
        begin
            if (t.minute >= LAST_MIN)
            begin
                t.minute = 6'd0;
                t = step_hour(t, 1'b1);
            end
            else
                t.minute = t.minute + 6'd1;
        end
        else
        begin
            if (t.minute == 6'd0)
            begin
                t.minute = LAST_MIN;
                t = step_hour(t, 1'b0);
            end
            else
                t.minute = t.minute - 6'd1;
        end
        return t;
    endfunction

    function automatic datetime_t step_second(datetime_t t, bit up);
        if (up)
        begin
            if (t.second >= LAST_SEC)
            begin
                t.second = 6'd0;
                t = step_minute(t, 1'b1);
            end
            else
                t.second = t.second + 6'd1;
        end
        else
        begin
            if (t.second == 6'd0)
            begin
                t.second = LAST_SEC;
                t = step_minute(t, 1'b0);
            end
            else
                t.second = t.second - 6'd1;
        end
        return t;
    endfunction

    // julian-style day count, year counted from march
    function automatic logic [22:0] day_number_of(datetime_t t);
        int unsigned a;
        int unsigned yy;
        int unsigned mm;
        int unsigned dn;
        a  = (t.month <= 4'd2) ? 1 : 0;
        yy = int'(t.year) + 4800 - a;
        mm = int'(t.month) + 12 * a - 3;
        dn = int'(t.day) + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - 32083;
        return dn[22:0];
    endfunction

    // applies one item to cal_now and returns the result the block should give
    function automatic calendar_result_t predict_step(step_item_t it);
        calendar_result_t r;
        bit               ok;
        r.load_error = 1'b0;
        case (it.mode)
            MODE_LOAD:
            begin
                ok = (it.load.second <= LAST_SEC) && (it.load.minute <= LAST_MIN) &&
                     (it.load.hour <= LAST_HOUR) && (it.load.month >= 4'd1) &&
                     (it.load.month <= LAST_MONTH) && (it.load.year <= MAX_YEAR) &&
                     (it.load.day >= 5'd1);
                if (ok && int'(it.load.day) > days_in_month(int'(it.load.month),
                                                            int'(it.load.year)))
                    ok = 1'b0;
                if (ok)
                    cal_now = it.load;
                else
                    r.load_error = 1'b1;
            end
            MODE_ADD_SEC:   cal_now = step_second(cal_now, 1'b1);
            MODE_ADD_MIN:   cal_now = step_minute(cal_now, 1'b1);
            MODE_ADD_HOUR:  cal_now = step_hour(cal_now, 1'b1);
            MODE_ADD_DAY:   cal_now = step_day(cal_now, 1'b1);
            MODE_ADD_MONTH: cal_now = step_month(cal_now, 1'b1);
            MODE_ADD_YEAR:  cal_now = step_year(cal_now, 1'b1);
            MODE_SUB_SEC:   cal_now = step_second(cal_now, 1'b0);
            MODE_SUB_MIN:   cal_now = step_minute(cal_now, 1'b0);
            MODE_SUB_HOUR:  cal_now = step_hour(cal_now, 1'b0);
            MODE_SUB_DAY:   cal_now = step_day(cal_now, 1'b0);
            MODE_SUB_MONTH: cal_now = step_month(cal_now, 1'b0);
            MODE_SUB_YEAR:  cal_now = step_year(cal_now, 1'b0);
            default: ;
        endcase
        r.dt         = cal_now;
        r.day_number = day_number_of(cal_now);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic step_item_t item_of(logic [3:0] mode, int y, int mo, int d,
                                           int h, int mi, int s);
        step_item_t it;
        it.mode        = mode;
        it.load.year   = 14'(y);
        it.load.month  = 4'(mo);
        it.load.day    = 5'(d);
        it.load.hour   = 5'(h);
        it.load.minute = 6'(mi);
        it.load.second = 6'(s);
        return it;
    endfunction

    function automatic calendar_result_t result_of(int y, int mo, int d, int h, int mi, int s,
                                                   int dn, bit err);
        calendar_result_t r;
        r.dt         = item_of(MODE_LOAD, y, mo, d, h, mi, s).load;
        r.day_number = 23'(dn);
        r.load_error = err;
        return r;
    endfunction

    // low end, high end or anything between
    function automatic int pick_edge(int lo, int hi);
        case ($urandom_range(0, 2))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // mostly steps; loads lean on boundary dates so that carries and borrows run deep
    function automatic step_item_t random_item();
        step_item_t it;
        int         r;
        int         y;
        int         mo;
        int         len;
        it.load = 40'({$urandom(), $urandom()});
        r = $urandom_range(0, 99);
        if (r < 8)
            it.mode = MODE_LOAD;   // raw fields, mostly invalid
        else if (r < 22)
        begin
            case ($urandom_range(0, 5))
                0:       y = 0;
                1:       y = int'(MAX_YEAR);
                2:       y = (($urandom_range(0, 3) == 0) ? 1900 : 2000) +
                             100 * $urandom_range(0, 2);
                default: y = $urandom_range(int'(MAX_YEAR), 0);
            endcase
            mo  = ($urandom_range(0, 3) == 0) ? 2 : pick_edge(1, int'(LAST_MONTH));
            len = days_in_month(mo, y);
            // now and then one day too many: past the month end
            it = item_of(MODE_LOAD, y, mo,
                         ($urandom_range(0, 7) == 0) ? len + 1 : pick_edge(1, len),
                         pick_edge(0, int'(LAST_HOUR)), pick_edge(0, int'(LAST_MIN)),
                         pick_edge(0, int'(LAST_SEC)));
        end
        else if (r < 25)
            it.mode = 4'($urandom_range(int'(MODE_SPARE_HI), int'(MODE_SPARE_LO)));
        else
            it.mode = 4'($urandom_range(int'(MODE_SUB_YEAR), int'(MODE_ADD_SEC)));
        return it;
    endfunction

    // drives one transaction, waits for the handshake, records the expected result,
    // then idles the sender for a while depending on the phase
    task automatic send_item(step_item_t it, bit typed, calendar_result_t want);
        calendar_result_t predicted;
        int               gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.load;
        s_axis_tuser  <= it.mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = predict_step(it);
        expected_results.push_back(typed ? want : predicted);
        gap = 0;
        while (gap < MAX_SENDER_GAP && $urandom_range(0, 99) < SEND_IDLE_PCT[phase])
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned seen);
        if (want != seen)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        end
    endtask

    // ---------------------------------------------------------------
    // receiver side
    // ---------------------------------------------------------------

    // tready toggles at random according to the phase
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= RECV_STALL_PCT[phase]);
    end

    // every output transaction is checked against the oldest expectation, field by field
    always @(posedge clk)
    begin
        calendar_result_t want;
        calendar_result_t seen;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = {m_axis_tuser[0], m_axis_tdata[62:0]};
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, seen);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("cur_second", want.dt.second, seen.dt.second);
                check_field("cur_minute", want.dt.minute, seen.dt.minute);
                check_field("cur_hour", want.dt.hour, seen.dt.hour);
                check_field("cur_day", want.dt.day, seen.dt.day);
                check_field("cur_month", want.dt.month, seen.dt.month);
                check_field("cur_year", want.dt.year, seen.dt.year);
                check_field("day_number", want.day_number, seen.day_number);
                check_field("load_error", want.load_error, seen.load_error);
            end
        end
    end

    // watchdog: too long without any transaction on either side ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        cal_now = '{year: RESET_YEAR, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
                    second: 6'd0};

        // directed table; hand-typed results only after reset, at the extremes and for the
        // all-ones load error
        stim_rows.push_back('{item_of(MODE_SPARE_HI, 0, 0, 0, 0, 0, 0), 1'b1,
                              result_of(2000, 1, 1, 0, 0, 0, 2451558, 1'b0)});
        stim_rows.push_back('{item_of(MODE_LOAD, 16383, 15, 31, 31, 63, 63), 1'b1,
                              result_of(2000, 1, 1, 0, 0, 0, 2451558, 1'b1)});
        stim_rows.push_back('{item_of(MODE_LOAD, 9999, 12, 31, 23, 59, 59), 1'b1,
                              result_of(9999, 12, 31, 23, 59, 59, 5373557, 1'b0)});
        // full carry through the year wrap, then the full borrow back
        stim_rows.push_back('{item_of(MODE_ADD_SEC, 0, 0, 0, 0, 0, 0), 1'b1,
                              result_of(0, 1, 1, 0, 0, 0, 1721058, 1'b0)});
        stim_rows.push_back('{item_of(MODE_SUB_SEC, 0, 0, 0, 0, 0, 0), 1'b1,
                              result_of(9999, 12, 31, 23, 59, 59, 5373557, 1'b0)});
        stim_rows.push_back('{item_of(MODE_SUB_MIN, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_SUB_HOUR, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_SUB_DAY, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        // year wrap up from the top year, then down from year zero
        stim_rows.push_back('{item_of(MODE_ADD_YEAR, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_SUB_YEAR, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        // month step leaves day 31 in february, a day step then carries to march
        stim_rows.push_back('{item_of(MODE_LOAD, 2024, 1, 31, 12, 30, 45), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_ADD_MONTH, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_ADD_DAY, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_ADD_HOUR, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_ADD_MIN, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        // day past the month end, borrowed back to the last day of the month before
        stim_rows.push_back('{item_of(MODE_LOAD, 2023, 3, 31, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_SUB_MONTH, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_SUB_DAY, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        // leap day in a 400-year, then in a plain century year
        stim_rows.push_back('{item_of(MODE_LOAD, 2000, 2, 29, 6, 7, 8), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_LOAD, 1900, 2, 29, 6, 7, 8), 1'b0, '0});
        // day, month and year out of range one at a time, then all three time fields at once
        stim_rows.push_back('{item_of(MODE_LOAD, 2010, 5, 0, 1, 1, 1), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_LOAD, 2010, 13, 1, 1, 1, 1), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_LOAD, 10000, 5, 1, 1, 1, 1), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_LOAD, 2010, 5, 1, 24, 60, 60), 1'b0, '0});
        stim_rows.push_back('{item_of(MODE_SPARE_LO, 0, 0, 0, 0, 0, 0), 1'b0, '0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);

        // random transactions through every idling phase
        for (int p = int'(PH_STEADY); p <= int'(PH_BOTH_IDLE); p++)
        begin
            phase = idle_phase_t'(p);
            repeat (ITEMS_PER_PHASE)
                send_item(random_item(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        // drain; the watchdog catches a result that never comes
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
